>>> src/spq_pkg.sv
`default_nettype none

package spq_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } spq_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } spq_stat_t;

endpackage

`default_nettype wire

>>> src/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_ctrl_t ctrl
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    in_stall     = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the result register to free up
        if (!stat.out_busy) begin
          ctrl.execute = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/spq_dp.sv
`default_nettype none

module spq_dp #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_ctrl_t ctrl,
  output spq_pkg::spq_stat_t stat,
  input  logic [1:0]         command,
  input  logic signed [15:0] in_priority,
  input  logic [31:0]        in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [15:0] out_priority,
  output logic [31:0]        out_payload,
  output logic [3:0]         occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]         cmd_q;
  logic signed [15:0] pri_q;
  logic [31:0]        pl_q;

  logic signed [15:0] slot_pri [DEPTH];
  logic [31:0]        slot_pl  [DEPTH];
  logic [CW-1:0]      count;

  logic signed [15:0] up_pri   [DEPTH];
  logic [31:0]        up_pl    [DEPTH];
  logic signed [15:0] down_pri [DEPTH];
  logic [31:0]        down_pl  [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   prev_gt;
  logic [DEPTH-1:0]   at_count;

  logic full;
  logic empty;
  logic do_enq;
  logic do_deq;

  logic [1:0]         res_status;
  logic signed [15:0] res_pri;
  logic [31:0]        res_pl;

  // input item register
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command;
      pri_q <= in_priority;
      pl_q  <= in_payload;
    end
  end

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_enq = ctrl.execute && (cmd_q == CMD_ENQ) && !full;
  assign do_deq = ctrl.execute && (cmd_q == CMD_DEQ) && !empty;

  // per-slot compare and neighbour selection
  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    assign gt[k]       = (CW'(k) < count) && (pri_q < slot_pri[k]);
    assign at_count[k] = (CW'(k) == count);

    if (k == 0) begin : g_first
      assign prev_gt[k] = 1'b0;
      assign up_pri[k]  = pri_q;
      assign up_pl[k]   = pl_q;
    end else begin : g_rest
      assign prev_gt[k] = gt[k-1];
      assign up_pri[k]  = slot_pri[k-1];
      assign up_pl[k]   = slot_pl[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign down_pri[k] = slot_pri[k];
      assign down_pl[k]  = slot_pl[k];
    end else begin : g_inner
      assign down_pri[k] = slot_pri[k+1];
      assign down_pl[k]  = slot_pl[k+1];
    end

    always_ff @(posedge clk) begin
      if (do_enq) begin
        if (prev_gt[k]) begin
          slot_pri[k] <= up_pri[k];
          slot_pl[k]  <= up_pl[k];
        end else if (gt[k] || at_count[k]) begin
          slot_pri[k] <= pri_q;
          slot_pl[k]  <= pl_q;
        end
      end else if (do_deq) begin
        slot_pri[k] <= down_pri[k];
        slot_pl[k]  <= down_pl[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_enq) begin
      count <= count + CW'(1);
    end else if (do_deq) begin
      count <= count - CW'(1);
    end
  end

  // result of the held command
  always_comb begin
    res_status = ST_OK;
    res_pri    = '0;
    res_pl     = '0;
    unique case (cmd_q) inside
      CMD_ENQ: begin
        if (full) begin
          res_status = ST_FULL;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_pri = slot_pri[0];
          res_pl  = slot_pl[0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      status       <= res_status;
      out_priority <= res_pri;
      out_payload  <= res_pl;
    end
  end

  // count is not yet updated when the result is loaded, so derive it
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      if (do_enq) begin
        occupancy <= 4'(count + CW'(1));
      end else if (do_deq) begin
        occupancy <= 4'(count - CW'(1));
      end else begin
        occupancy <= 4'(count);
      end
    end
  end

  assign stat.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

>>> src/sorted_priority_queue.sv
// an accepted item is registered, then its result; execute waits while the result is held
// a new item is taken only in idle, after the execute state has finished the last one
// each command is finished when execute is asserted: all slots compare and shift in parallel
// reset: synchronous active-high rst empties the queue and drops any pending result
// slot contents are not cleared by reset; only slots below the fill count ever affect a result
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [15:0] in_priority,
  input  logic [31:0]        in_payload,
  // result item channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [15:0] out_priority,
  output logic [31:0]        out_payload,
  output logic [3:0]         occupancy
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;
  spq_stat_t stat;

  // controller: idle takes an item, execute waits for the result register
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath: sorted slot row, fill count and result register
  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .in_priority  (in_priority),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
  );

`ifndef NO_ASSERTIONS
  // an accepted item puts the controller into execute, which holds off the next one
  a_accept_blocks : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted without entering execute");

  // a full report only when the queue holds its depth
  a_full_count : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> occupancy == 4'(DEPTH))
    else $error("full reported with queue not full");

  // an empty report carries no entry and an empty queue
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |->
      (occupancy == 4'd0) && (out_priority == 16'sd0) && (out_payload == 32'd0))
    else $error("empty report with stale entry or count");
`endif

endmodule

`default_nettype wire

>>> tb/sorted_priority_queue_test.sv
`default_nettype none

module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int QDEPTH = 8;
  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // cycles with no handshake on either side before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1800;
  // cycles allowed after the last result for anything stray to appear
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    status_t            status;
    logic signed [15:0] prio;
    logic [31:0]        payload;
    logic [3:0]         occupancy;
  } queue_result_t;

  // mirror of the sorted store plus the results still owed by the block
  class queue_scoreboard;
    logic signed [15:0] mirror_prio[QDEPTH];
    logic [31:0]        mirror_payload[QDEPTH];
    int                 mirror_count;
    queue_result_t      awaited_results[$];
    int n_enq, n_deq, n_peek, n_unused;
    int n_full, n_empty, n_checked, n_errors, peak_fill;

    function new();
      mirror_count = 0;
      n_enq = 0; n_deq = 0; n_peek = 0; n_unused = 0;
      n_full = 0; n_empty = 0; n_checked = 0; n_errors = 0; peak_fill = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_command(logic [1:0] cmd, logic signed [15:0] prio, logic [31:0] data);
      queue_result_t r;
      int            pos;
      r.status    = ST_OK;
      r.prio      = '0;
      r.payload   = '0;
      if (cmd == CMD_ENQ) begin
        n_enq++;
        if (mirror_count >= QDEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // new entry goes behind every entry of equal priority
          pos = mirror_count;
          for (int k = mirror_count - 1; k >= 0; k--)
            if (prio < mirror_prio[k]) pos = k;
          for (int k = mirror_count; k > pos; k--) begin
            mirror_prio[k]    = mirror_prio[k-1];
            mirror_payload[k] = mirror_payload[k-1];
          end
          mirror_prio[pos]    = prio;
          mirror_payload[pos] = data;
          mirror_count++;
          if (mirror_count > peak_fill) peak_fill = mirror_count;
        end
      end else if (cmd == CMD_DEQ || cmd == CMD_PEEK) begin
        if (cmd == CMD_DEQ) n_deq++;
        else n_peek++;
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.prio    = mirror_prio[0];
          r.payload = mirror_payload[0];
          if (cmd == CMD_DEQ) begin
            for (int k = 1; k < mirror_count; k++) begin
              mirror_prio[k-1]    = mirror_prio[k];
              mirror_payload[k-1] = mirror_payload[k];
            end
            mirror_count--;
          end
        end
      end else begin
        n_unused++;
      end
      r.occupancy = mirror_count[3:0];
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [15:0] prio, logic [31:0] data,
                               logic [3:0] occ);
      queue_result_t e;
      n_checked++;
      if (awaited_results.size() == 0) begin
        n_errors++;
        $write("%0t: unexpected result, expected none, actual status %0d prio %0d",
               $time, st, prio);
        $display(" payload %08h occupancy %0d", data, occ);
        return;
      end
      e = awaited_results.pop_front();
      if (st !== e.status || prio !== e.prio || data !== e.payload || occ !== e.occupancy) begin
        n_errors++;
        $write("%0t: mismatch, expected status %0d prio %0d payload %08h occ %0d,",
               $time, e.status, e.prio, e.payload, e.occupancy);
        $display(" actual status %0d prio %0d payload %08h occ %0d", st, prio, data, occ);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = 2'd0;
  logic signed [15:0] in_priority = '0;
  logic [31:0]        in_payload = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [15:0] out_priority;
  logic [31:0]        out_payload;
  logic [3:0]         occupancy;

  // random idling on both sides, switched off for one long stretch
  logic               idling_on = 1'b1;
  int                 quiet_cycles = 0;
  queue_scoreboard    sb;

  sorted_priority_queue #(.DEPTH(QDEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .in_priority  (in_priority),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: occasional random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idling_on && ($urandom_range(99) < 6);
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, out_priority, out_payload, occupancy);
    end
  end

  // watchdog: gives up if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one item, hold it until accepted, then hand it to the scoreboard
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] prio,
                           input logic [31:0] data);
    int gap;
    if (idling_on && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    in_priority <= prio;
    in_payload  <= data;
    // the edge at which stall was low is the accepting edge
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(cmd, prio, data);
  endtask

  // sender holds off until the block has returned every owed result
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // half the time a handful of close values so ties are common, sometimes the extremes
  function automatic logic [15:0] pick_priority();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return 16'($urandom_range(7)) - 16'd4;
    if (roll == 5) return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return 16'($urandom());
  endfunction

  // bias 0 fills the queue, bias 1 empties it, anything else is balanced
  function automatic logic [1:0] pick_command(int bias);
    int roll;
    int enq_pct;
    int deq_pct;
    if ($urandom_range(99) < 3) return CMD_UNUSED;
    case (bias)
      0: begin
        enq_pct = 70;
        deq_pct = 20;
      end
      1: begin
        enq_pct = 25;
        deq_pct = 60;
      end
      default: begin
        enq_pct = 45;
        deq_pct = 40;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < enq_pct) return CMD_ENQ;
    if (roll < enq_pct + deq_pct) return CMD_DEQ;
    return CMD_PEEK;
  endfunction

  initial begin
    int bias;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: dequeue, peek and the unused code
    send_item(CMD_DEQ, 16'($urandom()), $urandom());
    send_item(CMD_PEEK, 16'($urandom()), $urandom());
    send_item(CMD_UNUSED, 16'($urandom()), $urandom());
    // extremes of priority and payload, then a tie at zero
    send_item(CMD_ENQ, 16'h7fff, 32'h0000_0000);
    send_item(CMD_ENQ, 16'h8000, 32'hffff_ffff);
    send_item(CMD_ENQ, 16'h0000, 32'ha5a5_a5a5);
    send_item(CMD_ENQ, 16'h0000, 32'h5a5a_5a5a);
    send_item(CMD_PEEK, 16'h0, 32'h0);
    // unused code on a non-empty queue leaves it alone
    send_item(CMD_UNUSED, 16'h8000, 32'hffff_ffff);
    // fill up, with ties at both extremes
    send_item(CMD_ENQ, 16'hffff, 32'h1111_1111);
    send_item(CMD_ENQ, 16'h0001, 32'h2222_2222);
    send_item(CMD_ENQ, 16'h7fff, 32'h3333_3333);
    send_item(CMD_ENQ, 16'h8000, 32'h4444_4444);
    // full queue refuses the entry
    send_item(CMD_ENQ, 16'h8000, 32'hdead_beef);
    send_item(CMD_PEEK, 16'h0, 32'h0);
    // drain completely, one past empty
    repeat (QDEPTH) send_item(CMD_DEQ, 16'($urandom()), $urandom());
    send_item(CMD_DEQ, 16'h0, 32'h0);

    // random part: phases that push the queue towards full or empty
    bias = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) bias = $urandom_range(2);
      // hold off twice during the run so the block goes fully idle
      if (n == 600 || n == 1500) wait_for_drain();
      // long stretch with no idling on either side
      if (n == 900) idling_on <= 1'b0;
      if (n == 1300) idling_on <= 1'b1;
      send_item(pick_command(bias), pick_priority(), $urandom());
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d commands: %0d enqueue, %0d dequeue, %0d peek, %0d unused code",
             sb.n_enq + sb.n_deq + sb.n_peek + sb.n_unused,
             sb.n_enq, sb.n_deq, sb.n_peek, sb.n_unused);
    $display("%0d results checked, %0d full and %0d empty responses, peak fill %0d, %0d errors",
             sb.n_checked, sb.n_full, sb.n_empty, sb.peak_fill, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
